// ===== hdl/radial_distortion_remap_core_assert.svh =====
// Assertion macros shared by the checker of the radial remap core.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef RADIAL_DISTORTION_REMAP_CORE_ASSERT_SVH
`define RADIAL_DISTORTION_REMAP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define RDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define RDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rdr_pkg.sv =====
// Package of the radial distortion remap core: defaults, fixed-point
// constants and register map. No dependencies.
package rdr_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int FRACTION_BITS_DEF = 16;
    // Fractional bits of the distance (Q12.8)
    localparam int DIST_FRAC         = 8;
    localparam int STRENGTH_BITS     = 8;

    localparam int ADDR_W  = 5;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 32;

    localparam logic [INDEX_W-1:0] REG_CENTER_X      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_CENTER_Y      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_RADIUS        = 3'd2;
    localparam logic [INDEX_W-1:0] REG_STRENGTH      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

    localparam int RADIUS_RESET        = 100;
    localparam int STRENGTH_RESET      = 10;
    localparam int SCREEN_WIDTH_RESET  = 1920;
    localparam int SCREEN_HEIGHT_RESET = 1080;

endpackage

// ===== hdl/rdr_pixel_if.sv =====
// Pixel coordinate channel into the radial remap core.
// Valid/ready handshake; no dependencies.
interface rdr_pixel_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== hdl/rdr_remap_if.sv =====
// Remap result channel out of the radial remap core.
// Valid/ready handshake; no dependencies.
interface rdr_remap_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic                  remapped;
    logic [COORD_BITS-1:0] source_x;
    logic [COORD_BITS-1:0] source_y;

    modport source (output valid, output remapped, output source_x, output source_y,
                    input ready);
    modport sink   (input valid, input remapped, input source_x, input source_y,
                    output ready);
endinterface

// ===== hdl/rdr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Uses rdr_pkg only for house consistency; no submodules.
module rdr_isqrt
    import rdr_pkg::*;
#(
    parameter int IN_W   = 40,
    parameter int SIDE_W = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_op,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic              valid_reg [0:ROOT_W-1];
    logic [IN_W-1:0]   op_reg    [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic              cur_valid;
            logic [IN_W-1:0]   cur_op;
            logic [REM_W-1:0]  cur_rem;
            logic [ROOT_W-1:0] cur_root;
            logic [SIDE_W-1:0] cur_side;
            logic [REM_W-1:0]  rem4;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (k == 0) begin : g_first
                assign cur_valid = in_valid;
                assign cur_op    = in_op;
                assign cur_rem   = '0;
                assign cur_root  = '0;
                assign cur_side  = in_side;
            end
            else begin : g_next
                assign cur_valid = valid_reg[k-1];
                assign cur_op    = op_reg[k-1];
                assign cur_rem   = rem_reg[k-1];
                assign cur_root  = root_reg[k-1];
                assign cur_side  = side_reg[k-1];
            end

            // Bring down the next two operand bits and try 4*root+1
            assign rem4  = {cur_rem[REM_W-3:0], cur_op[IN_W-1 -: 2]};
            assign trial = {1'b0, cur_root, 2'b01};
            assign take  = (rem4 >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= cur_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    op_reg[k]   <= {cur_op[IN_W-3:0], 2'b00};
                    rem_reg[k]  <= take ? (rem4 - trial) : rem4;
                    root_reg[k] <= {cur_root[ROOT_W-2:0], take};
                    side_reg[k] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hdl/rdr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Expects the upper numerator part below the divisor. No submodules.
module rdr_div
    import rdr_pkg::*;
#(
    parameter int DEN_W  = 12,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [DEN_W-1:0]  den,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_num_hi,
    input  logic [Q_W-1:0]    in_num_lo,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [0:Q_W-1];
    logic [DEN_W-1:0]  rem_reg   [0:Q_W-1];
    logic [Q_W-1:0]    lo_reg    [0:Q_W-1];
    logic [Q_W-1:0]    quot_reg  [0:Q_W-1];
    logic [SIDE_W-1:0] side_reg  [0:Q_W-1];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic              cur_valid;
            logic [DEN_W-1:0]  cur_rem;
            logic [Q_W-1:0]    cur_lo;
            logic [Q_W-1:0]    cur_quot;
            logic [SIDE_W-1:0] cur_side;
            logic [DEN_W:0]    part;
            logic [DEN_W:0]    diff;
            logic              take;

            if (k == 0) begin : g_first
                assign cur_valid = in_valid;
                assign cur_rem   = in_num_hi;
                assign cur_lo    = in_num_lo;
                assign cur_quot  = '0;
                assign cur_side  = in_side;
            end
            else begin : g_next
                assign cur_valid = valid_reg[k-1];
                assign cur_rem   = rem_reg[k-1];
                assign cur_lo    = lo_reg[k-1];
                assign cur_quot  = quot_reg[k-1];
                assign cur_side  = side_reg[k-1];
            end

            // Shift in one numerator bit, subtract the divisor if it fits
            assign part = {cur_rem, cur_lo[Q_W-1]};
            assign diff = part - {1'b0, den};
            assign take = (part >= {1'b0, den});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= cur_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
                    lo_reg[k]   <= cur_lo << 1;
                    quot_reg[k] <= {cur_quot[Q_W-2:0], take};
                    side_reg[k] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== hdl/radial_distortion_remap_core.sv =====
// Radial lens distortion remap core.
// Takes one destination pixel per item on pixel_in and returns on remap_out
// whether it is remapped and the source pixel it reads from. Inside the disc
// of the configured radius around the center the source is pulled along the
// offset from the center by d * (1 - distance/radius) * strength.
// Registers sit on an APB-style port (pready always high): center x/y,
// radius, strength, screen width and height, at byte addresses 4*index.
// Write them only while no item is in flight.
// Throughput: one item per cycle while remap_out does not stall. Stages: offsets,
// squares, disc test, the square root (one root bit per stage), the divider (one
// quotient bit per stage), the amount, the products and the output register.
// Reset empties the pipeline and loads the register defaults.
// When remap_out stalls every stage holds, and pixel_in.ready drops in the
// same cycle; the last stage is the output register.
// Depends on rdr_pkg, rdr_pixel_if, rdr_remap_if, rdr_isqrt, rdr_div.
module radial_distortion_remap_core
    import rdr_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    rdr_pixel_if.sink          pixel_in,
    rdr_remap_if.source        remap_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int C      = COORD_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int SQ_W   = 2 * C + 2 * DIST_FRAC;
    localparam int DQ_W   = SQ_W / 2;
    localparam int SIDE_W = 4 * C + 3;
    localparam int M1_W   = C + F + 1;
    localparam int M2_W   = M1_W + STRENGTH_BITS;
    localparam int SH_W   = M2_W - F;
    localparam int SRC_W  = SH_W + 2;

    // ---------------- configuration registers ----------------
    logic [C-1:0]             center_x_reg;
    logic [C-1:0]             center_y_reg;
    logic [C-1:0]             radius_reg;
    logic [STRENGTH_BITS-1:0] strength_reg;
    logic [C:0]               screen_width_reg;
    logic [C:0]               screen_height_reg;
    logic [2*C-1:0]           rsq_reg;
    logic [INDEX_W-1:0]       reg_index;
    logic                     cfg_write;

    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            radius_reg        <= C'(RADIUS_RESET);
            strength_reg      <= STRENGTH_BITS'(STRENGTH_RESET);
            screen_width_reg  <= (C+1)'(SCREEN_WIDTH_RESET);
            screen_height_reg <= (C+1)'(SCREEN_HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_CENTER_X:      center_x_reg      <= pwdata[C-1:0];
                REG_CENTER_Y:      center_y_reg      <= pwdata[C-1:0];
                REG_RADIUS:        radius_reg        <= pwdata[C-1:0];
                REG_STRENGTH:      strength_reg      <= pwdata[STRENGTH_BITS-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[C:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[C:0];
                default:           ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_index)
            REG_CENTER_X:      prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:      prdata = DATA_W'(center_y_reg);
            REG_RADIUS:        prdata = DATA_W'(radius_reg);
            REG_STRENGTH:      prdata = DATA_W'(strength_reg);
            REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Square of the radius for the disc test; the user keeps config quiet during items, the block does not enforce it
    always_ff @(posedge clk)
    begin
        rsq_reg <= radius_reg * radius_reg;
    end

    // ---------------- pipeline enable ----------------
    logic en;
    logic out_valid_reg;

    assign en             = !out_valid_reg || remap_out.ready;
    assign pixel_in.ready = en;

    // ---------------- stage 0: offsets and screen test ----------------
    logic         s0_valid_reg;
    logic [C-1:0] s0_px_reg, s0_py_reg, s0_adx_reg, s0_ady_reg;
    logic         s0_sgnx_reg, s0_sgny_reg, s0_onscr_reg;
    logic [C:0]   dx, dy;

    assign dx = {1'b0, pixel_in.pixel_x} - {1'b0, center_x_reg};
    assign dy = {1'b0, pixel_in.pixel_y} - {1'b0, center_y_reg};

    // ---------------- stage 1: squares ----------------
    logic           s1_valid_reg;
    logic [C-1:0]   s1_px_reg, s1_py_reg, s1_adx_reg, s1_ady_reg;
    logic           s1_sgnx_reg, s1_sgny_reg, s1_onscr_reg;
    logic [2*C-1:0] s1_x2_reg, s1_y2_reg;

    // ---------------- stage 2: disc test and root operand ----------------
    logic              s2_valid_reg;
    logic [SQ_W-1:0]   s2_op_reg;
    logic [SIDE_W-1:0] s2_side_reg;
    logic [2*C:0]      d2;
    logic              in_disc;

    assign d2      = {1'b0, s1_x2_reg} + {1'b0, s1_y2_reg};
    assign in_disc = s1_onscr_reg && (d2 < {1'b0, rsq_reg});

    // Advance the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= pixel_in.valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_px_reg    <= pixel_in.pixel_x;
            s0_py_reg    <= pixel_in.pixel_y;
            s0_sgnx_reg  <= dx[C];
            s0_sgny_reg  <= dy[C];
            s0_adx_reg   <= dx[C] ? C'(-dx) : dx[C-1:0];
            s0_ady_reg   <= dy[C] ? C'(-dy) : dy[C-1:0];
            s0_onscr_reg <= ({1'b0, pixel_in.pixel_x} < screen_width_reg) &&
                            ({1'b0, pixel_in.pixel_y} < screen_height_reg);

            s1_px_reg    <= s0_px_reg;
            s1_py_reg    <= s0_py_reg;
            s1_adx_reg   <= s0_adx_reg;
            s1_ady_reg   <= s0_ady_reg;
            s1_sgnx_reg  <= s0_sgnx_reg;
            s1_sgny_reg  <= s0_sgny_reg;
            s1_onscr_reg <= s0_onscr_reg;
            s1_x2_reg    <= s0_adx_reg * s0_adx_reg;
            s1_y2_reg    <= s0_ady_reg * s0_ady_reg;

            s2_op_reg    <= in_disc ? (SQ_W'(d2[2*C-1:0]) << (2 * DIST_FRAC)) : '0;
            s2_side_reg  <= {s1_px_reg, s1_py_reg, s1_sgnx_reg, s1_sgny_reg,
                             s1_adx_reg, s1_ady_reg, in_disc};
        end
    end

    // ---------------- distance, Q.8 ----------------
    logic              sq_valid;
    logic [DQ_W-1:0]   dist_q;
    logic [SIDE_W-1:0] sq_side;

    rdr_isqrt #(
        .IN_W   (SQ_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_op     (s2_op_reg),
        .in_side   (s2_side_reg),
        .out_valid (sq_valid),
        .out_root  (dist_q),
        .out_side  (sq_side)
    );

    // ---------------- ratio = distance / radius, Q.F ----------------
    logic              dv_valid;
    logic [F-1:0]      ratio;
    logic [SIDE_W-1:0] dv_side;
    logic [F-1:0]      num_lo;

    assign num_lo = F'(dist_q[DIST_FRAC-1:0]) << (F - DIST_FRAC);

    rdr_div #(
        .DEN_W  (C),
        .Q_W    (F),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .den       (radius_reg),
        .in_valid  (sq_valid),
        .in_num_hi (dist_q[DQ_W-1:DIST_FRAC]),
        .in_num_lo (num_lo),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quot  (ratio),
        .out_side  (dv_side)
    );

    // ---------------- back stages: amount, products, source ----------------
    logic              am_valid_reg, m1_valid_reg, m2_valid_reg;
    logic [F:0]        am_amount_reg;
    logic [SIDE_W-1:0] am_side_reg, m1_side_reg, m2_side_reg;
    logic [M1_W-1:0]   m1_x_reg, m1_y_reg;
    logic [M2_W-1:0]   m2_x_reg, m2_y_reg;

    logic [C-1:0]      am_adx, am_ady, m2_px, m2_py;
    logic              m2_sgnx, m2_sgny, m2_inside;
    logic [SH_W-1:0]   shift_x, shift_y;
    logic [SRC_W-1:0]  src_x, src_y;
    logic              ok_x, ok_y;

    assign am_adx = am_side_reg[2*C:C+1];
    assign am_ady = am_side_reg[C:1];
    assign {m2_px, m2_py, m2_sgnx, m2_sgny} = m2_side_reg[SIDE_W-1:2*C+1];
    assign m2_inside = m2_side_reg[0];

    assign shift_x = m2_x_reg[M2_W-1:F];
    assign shift_y = m2_y_reg[M2_W-1:F];

    // Source is the pixel minus the signed shift
    assign src_x = m2_sgnx ? (SRC_W'(m2_px) + SRC_W'(shift_x))
                           : (SRC_W'(m2_px) - SRC_W'(shift_x));
    assign src_y = m2_sgny ? (SRC_W'(m2_py) + SRC_W'(shift_y))
                           : (SRC_W'(m2_py) - SRC_W'(shift_y));
    assign ok_x  = !src_x[SRC_W-1] && (src_x < SRC_W'(screen_width_reg));
    assign ok_y  = !src_y[SRC_W-1] && (src_y < SRC_W'(screen_height_reg));

    logic         out_remapped_reg;
    logic [C-1:0] out_sx_reg, out_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            am_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            am_valid_reg  <= dv_valid;
            m1_valid_reg  <= am_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_amount_reg <= ((F+1)'(1) << F) - {1'b0, ratio};
            am_side_reg   <= dv_side;

            m1_x_reg      <= M1_W'(am_adx) * M1_W'(am_amount_reg);
            m1_y_reg      <= M1_W'(am_ady) * M1_W'(am_amount_reg);
            m1_side_reg   <= am_side_reg;

            m2_x_reg      <= M2_W'(m1_x_reg) * M2_W'(strength_reg);
            m2_y_reg      <= M2_W'(m1_y_reg) * M2_W'(strength_reg);
            m2_side_reg   <= m1_side_reg;

            // Take the source only when inside the disc and both ends on screen
            out_remapped_reg <= m2_inside && ok_x && ok_y;
            out_sx_reg       <= (m2_inside && ok_x && ok_y) ? src_x[C-1:0] : m2_px;
            out_sy_reg       <= (m2_inside && ok_x && ok_y) ? src_y[C-1:0] : m2_py;
        end
    end

    assign remap_out.valid    = out_valid_reg;
    assign remap_out.remapped = out_remapped_reg;
    assign remap_out.source_x = out_sx_reg;
    assign remap_out.source_y = out_sy_reg;

endmodule

// ===== hdl/rdr_checker.sv =====
// Port-level checker for the radial remap core, bound to the top level.
// Depends on rdr_pkg and radial_distortion_remap_core_assert.svh.
`include "radial_distortion_remap_core_assert.svh"

module rdr_checker
    import rdr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  out_remapped,
    input logic [COORD_BITS-1:0] out_source_x,
    input logic [COORD_BITS-1:0] out_source_y,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [ADDR_W-1:0]     paddr,
    input logic [DATA_W-1:0]     pwdata,
    input logic [DATA_W-1:0]     prdata
);

    // A stalled result holds
    `RDR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_remapped) && $stable(out_source_x) && $stable(out_source_y), "stalled result changed")

    // Input is taken whenever the output register is free or draining
    `RDR_ASSERT_IMP(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output side")

    // A written centre column reads back in the next cycle
    `RDR_ASSERT_IMP(a_cfg_readback, (psel && penable && pwrite && paddr == '0) ##1 (psel && !pwrite && paddr == '0), prdata[COORD_BITS-1:0] == $past(pwdata[COORD_BITS-1:0]), "register readback mismatch")

endmodule

bind radial_distortion_remap_core rdr_checker #(
    .COORD_BITS (COORD_BITS)
) u_rdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pixel_in.ready),
    .out_valid    (remap_out.valid),
    .out_ready    (remap_out.ready),
    .out_remapped (remap_out.remapped),
    .out_source_x (remap_out.source_x),
    .out_source_y (remap_out.source_y),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);
